// ===== sv/union_find_redundant_edge_defines.svh =====
// Assertion macros shared by the redundant-edge detector.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef UNION_FIND_REDUNDANT_EDGE_DEFINES_SVH
`define UNION_FIND_REDUNDANT_EDGE_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define UFRE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("union find redundant edge: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define UFRE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("union find redundant edge: next-cycle check failed");

`endif

// ===== sv/ufre_pkg.sv =====
// Shared types, constants and helpers of the redundant-edge detector.
// No dependencies.
package ufre_pkg;

    localparam int NODES    = 1024;
    localparam int ID_W     = 10;
    localparam int ADDR_W   = $clog2(NODES);
    localparam int RANK_W   = 4;
    localparam logic [RANK_W-1:0] RANK_MAX = {RANK_W{1'b1}};

    typedef struct packed {
        logic [ID_W-1:0] node_a;
        logic [ID_W-1:0] node_b;
        logic            new_graph;
    } t_edge;

    typedef struct packed {
        logic            redundant;
        logic            answer_valid;
        logic [ID_W-1:0] answer_a;
        logic [ID_W-1:0] answer_b;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic [ADDR_W-1:0] raddr;
    } t_par_req;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [RANK_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_rank_req;

    function automatic logic in_graph(input logic [ID_W-1:0] id);
        return 32'(id) < 32'(NODES);
    endfunction

    function automatic logic [ADDR_W-1:0] to_addr(input logic [ID_W-1:0] id);
        return ADDR_W'(id);
    endfunction

endpackage

// ===== sv/ufre_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ufre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// ===== sv/ufre_seq.sv =====
// Sequencer of the redundant-edge detector: clear sweep, root walks,
// path compression, union by rank and the result register. Uses ufre_pkg.
module ufre_seq import ufre_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_edge             i_edge,
    output logic              o_busy,
    output logic              o_strobe,
    output t_result           o_result,
    output t_par_req          o_par_req,
    input  logic [ID_W-1:0]   i_par_q,
    output t_rank_req         o_rank_req,
    input  logic [RANK_W-1:0] i_rank_q
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CLEAR  = 4'd1;
    localparam logic [3:0] S_FSTART = 4'd2;
    localparam logic [3:0] S_WALK   = 4'd3;
    localparam logic [3:0] S_CSTART = 4'd4;
    localparam logic [3:0] S_COMP   = 4'd5;
    localparam logic [3:0] S_UNION  = 4'd6;
    localparam logic [3:0] S_RKA    = 4'd7;
    localparam logic [3:0] S_RKB    = 4'd8;

    logic [3:0]        r_state, n_state;
    logic [ID_W-1:0]   r_a, n_a;
    logic [ID_W-1:0]   r_b, n_b;
    logic              r_sel, n_sel;
    logic [ID_W-1:0]   r_root, n_root;
    logic [ID_W-1:0]   r_cur, n_cur;
    logic [ID_W-1:0]   r_ra, n_ra;
    logic [ID_W-1:0]   r_rb, n_rb;
    logic [RANK_W-1:0] r_rka, n_rka;
    logic [ADDR_W-1:0] r_clr, n_clr;
    logic              r_pend, n_pend;
    logic [ID_W-1:0]   r_lat_a, n_lat_a;
    logic [ID_W-1:0]   r_lat_b, n_lat_b;
    logic              r_lat_v, n_lat_v;
    logic              r_red, n_red;
    logic              r_strobe, n_strobe;

    logic [ID_W-1:0]   w_id;
    logic              w_root_done;

    assign w_id = r_sel ? r_b : r_a;

    always_comb begin
        n_state     = r_state;
        n_a         = r_a;
        n_b         = r_b;
        n_sel       = r_sel;
        n_root      = r_root;
        n_cur       = r_cur;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_rka       = r_rka;
        n_clr       = r_clr;
        n_pend      = r_pend;
        n_lat_a     = r_lat_a;
        n_lat_b     = r_lat_b;
        n_lat_v     = r_lat_v;
        n_red       = r_red;
        n_strobe    = 1'b0;
        w_root_done = 1'b0;
        o_par_req   = '0;
        o_rank_req  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_a   = i_edge.node_a;
                    n_b   = i_edge.node_b;
                    n_sel = 1'b0;
                    if (i_edge.new_graph) begin
                        n_lat_a = '0;
                        n_lat_b = '0;
                        n_lat_v = 1'b0;
                        n_pend  = 1'b1;
                        n_clr   = '0;
                        n_state = S_CLEAR;
                    end else begin
                        n_state = S_FSTART;
                    end
                end
            end
            S_CLEAR: begin
                o_par_req.we     = 1'b1;
                o_par_req.waddr  = r_clr;
                o_par_req.wdata  = ID_W'(r_clr);
                o_rank_req.we    = 1'b1;
                o_rank_req.waddr = r_clr;
                o_rank_req.wdata = '0;
                n_clr            = r_clr + 1'b1;
                if (r_clr == ADDR_W'(NODES - 1)) begin
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_FSTART : S_IDLE;
                end
            end
            S_FSTART: begin
                n_root = w_id;
                if (in_graph(w_id)) begin
                    o_par_req.raddr = to_addr(w_id);
                    n_state         = S_WALK;
                end else begin
                    n_state = S_CSTART;
                end
            end
            S_WALK: begin
                // stop at a self-parent or at an id outside the graph
                if (i_par_q == r_root || !in_graph(i_par_q)) begin
                    n_state = S_CSTART;
                end else begin
                    n_root          = i_par_q;
                    o_par_req.raddr = to_addr(i_par_q);
                end
            end
            S_CSTART: begin
                if (w_id == r_root) begin
                    w_root_done = 1'b1;
                end else begin
                    n_cur           = w_id;
                    o_par_req.raddr = to_addr(w_id);
                    n_state         = S_COMP;
                end
            end
            S_COMP: begin
                // point the current node at the root, advance along the old link
                o_par_req.we    = 1'b1;
                o_par_req.waddr = to_addr(r_cur);
                o_par_req.wdata = r_root;
                if (i_par_q == r_root || !in_graph(i_par_q)) begin
                    w_root_done = 1'b1;
                end else begin
                    n_cur           = i_par_q;
                    o_par_req.raddr = to_addr(i_par_q);
                end
            end
            S_UNION: begin
                if (r_ra == r_rb) begin
                    n_red    = 1'b1;
                    n_lat_a  = r_a;
                    n_lat_b  = r_b;
                    n_lat_v  = 1'b1;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end else if (in_graph(r_ra) && in_graph(r_rb)) begin
                    o_rank_req.raddr = to_addr(r_ra);
                    n_state          = S_RKA;
                end else begin
                    n_red    = 1'b0;
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_RKA: begin
                n_rka            = i_rank_q;
                o_rank_req.raddr = to_addr(r_rb);
                n_state          = S_RKB;
            end
            S_RKB: begin
                o_par_req.we = 1'b1;
                if (r_rka > i_rank_q) begin
                    o_par_req.waddr = to_addr(r_rb);
                    o_par_req.wdata = r_ra;
                end else begin
                    o_par_req.waddr = to_addr(r_ra);
                    o_par_req.wdata = r_rb;
                    if (r_rka == i_rank_q && i_rank_q != RANK_MAX) begin
                        o_rank_req.we    = 1'b1;
                        o_rank_req.waddr = to_addr(r_rb);
                        o_rank_req.wdata = i_rank_q + 1'b1;
                    end
                end
                n_red    = 1'b0;
                n_strobe = 1'b1;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_root_done) begin
            if (!r_sel) begin
                n_ra    = r_root;
                n_sel   = 1'b1;
                n_state = S_FSTART;
            end else begin
                n_rb    = r_root;
                n_state = S_UNION;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pend   <= 1'b0;
            r_sel    <= 1'b0;
            r_lat_a  <= '0;
            r_lat_b  <= '0;
            r_lat_v  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_pend   <= n_pend;
            r_sel    <= n_sel;
            r_lat_a  <= n_lat_a;
            r_lat_b  <= n_lat_b;
            r_lat_v  <= n_lat_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_b    <= n_b;
        r_root <= n_root;
        r_cur  <= n_cur;
        r_ra   <= n_ra;
        r_rb   <= n_rb;
        r_rka  <= n_rka;
        r_red  <= n_red;
    end

    assign o_busy                = (r_state != S_IDLE);
    assign o_strobe              = r_strobe;
    assign o_result.redundant    = r_red;
    assign o_result.answer_valid = r_lat_v;
    assign o_result.answer_a     = r_lat_a;
    assign o_result.answer_b     = r_lat_b;

endmodule

// ===== sv/union_find_redundant_edge.sv =====
// Union-find redundant-edge detector: one edge word per start, one result word per edge.
// Per accepted edge: a clear sweep if new_graph is set, then for each endpoint a root walk
// along its parent chain and a compression pass over that path, then the union step, which
// reads both ranks when two distinct roots merge. Busy drops in the strobe cycle, so the next
// word is taken there. Reset (synchronous, active low) and new_graph run a clear sweep over
// every node's parent and rank entry while busy is high; the receiver cannot stall the strobe.
module union_find_redundant_edge import ufre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_edge   i_edge,
    output logic    busy,
    output logic    o_strobe,
    output t_result o_result
);

`include "union_find_redundant_edge_defines.svh"

    // Memory request groups from the sequencer and read data back.
    t_par_req          w_par_req;
    t_rank_req         w_rank_req;
    logic [ID_W-1:0]   w_par_q;
    logic [RANK_W-1:0] w_rank_q;

    // Sequencer: owns the clear sweep, both root walks, compression and the union.
    ufre_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_edge     (i_edge),
        .o_busy     (busy),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .o_par_req  (w_par_req),
        .i_par_q    (w_par_q),
        .o_rank_req (w_rank_req),
        .i_rank_q   (w_rank_q)
    );

    // Parent store: one link per node, one read and one write per cycle.
    ufre_ram #(
        .WIDTH (ID_W),
        .DEPTH (NODES)
    ) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (w_par_req.we),
        .i_waddr (w_par_req.waddr),
        .i_wdata (w_par_req.wdata),
        .i_raddr (w_par_req.raddr),
        .o_rdata (w_par_q)
    );

    // Rank store: touched only by the clear sweep and the union step.
    ufre_ram #(
        .WIDTH (RANK_W),
        .DEPTH (NODES)
    ) u_rank_ram (
        .i_clk   (i_clk),
        .i_we    (w_rank_req.we),
        .i_waddr (w_rank_req.waddr),
        .i_wdata (w_rank_req.wdata),
        .i_raddr (w_rank_req.raddr),
        .o_rdata (w_rank_q)
    );

    // A result word appears only once the sequencer is back at rest.
    `UFRE_ASSERT_IMP(a_strobe_idle, o_strobe, !busy)
    // An accepted edge word keeps the block busy in the next cycle.
    `UFRE_ASSERT_NXT(a_start_busy, start && !busy, busy)
    // Memories change only while an edge or a clear sweep is in progress.
    `UFRE_ASSERT_IMP(a_write_busy, w_par_req.we || w_rank_req.we, busy)
    // A redundant edge always leaves a valid answer behind.
    `UFRE_ASSERT_IMP(a_red_valid, o_strobe && o_result.redundant, o_result.answer_valid)

endmodule

// ===== test/ufre_checker.sv =====
// Scoreboard for the union-find redundant-edge detector: keeps its own disjoint-set
// forest, predicts one result word per accepted edge word and compares in order.
// Depends on ufre_pkg for the word types and sizes.
module ufre_checker import ufre_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  logic    i_busy,
    input  t_edge   i_edge,
    input  logic    i_strobe,
    input  t_result i_result,
    output int      o_errors,
    output int      o_pending,
    output int      o_edges,
    output int      o_redundant,
    output int      o_clears,
    output int      o_deepest
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [ID_W-1:0]   links   [NODES];
    logic [RANK_W-1:0] heights [NODES];
    logic [ID_W-1:0]   last_a;
    logic [ID_W-1:0]   last_b;
    logic              have_answer;

    t_result answer_q [$];
    t_result want;

    function automatic logic on_graph(input logic [ID_W-1:0] id);
        return int'(id) < NODES;
    endfunction

    function automatic void clear_forest();
        for (int i = 0; i < NODES; i++) begin
            links[i]   = ID_W'(i);
            heights[i] = '0;
        end
        last_a      = '0;
        last_b      = '0;
        have_answer = 1'b0;
    endfunction

    // Walk to the root, then point every node on the path straight at it.
    function automatic logic [ID_W-1:0] find_leader(input logic [ID_W-1:0] id);
        logic [ID_W-1:0] lead;
        logic [ID_W-1:0] cur;
        logic [ID_W-1:0] nxt;
        int              steps;
        if (!on_graph(id))
            return id;
        lead  = id;
        steps = 0;
        while (steps < NODES) begin
            nxt = links[lead];
            if (nxt == lead || !on_graph(nxt))
                break;
            lead = nxt;
            steps++;
        end
        if (steps > o_deepest)
            o_deepest = steps;
        cur   = id;
        steps = 0;
        while (cur != lead && steps < NODES) begin
            nxt       = links[cur];
            links[cur] = lead;
            if (!on_graph(nxt))
                break;
            cur = nxt;
            steps++;
        end
        return lead;
    endfunction

    function automatic t_result apply_edge(input t_edge w);
        logic [ID_W-1:0] ra;
        logic [ID_W-1:0] rb;
        t_result         r;
        r = '0;
        if (w.new_graph)
            clear_forest();
        ra = find_leader(w.node_a);
        rb = find_leader(w.node_b);
        if (ra == rb) begin
            r.redundant = 1'b1;
            last_a      = w.node_a;
            last_b      = w.node_b;
            have_answer = 1'b1;
        end else if (on_graph(ra) && on_graph(rb)) begin
            if (heights[ra] > heights[rb]) begin
                links[rb] = ra;
            end else if (heights[ra] < heights[rb]) begin
                links[ra] = rb;
            end else begin
                links[ra] = rb;
                if (heights[rb] < RANK_MAX)
                    heights[rb] = heights[rb] + 1'b1;
            end
        end
        r.answer_valid = have_answer;
        r.answer_a     = last_a;
        r.answer_b     = last_b;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int wanted);
        $display("MISMATCH %s: got %0d, wanted %0d (after %0d edges)", what, got, wanted,
                 o_edges);
        o_errors++;
    endtask

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_edges     = 0;
        o_redundant = 0;
        o_clears    = 0;
        o_deepest   = 0;
        clear_forest();
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_forest();
            answer_q.delete();
        end else begin
            // Push first: a strobe on the same edge belongs to an older word.
            if (i_start && !i_busy) begin
                answer_q.push_back(apply_edge(i_edge));
                o_edges++;
                if (i_edge.new_graph)
                    o_clears++;
            end
            if (i_strobe) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("result word with nothing pending", int'(i_result), 0);
                end else begin
                    want = answer_q.pop_front();
                    if (i_result.redundant)
                        o_redundant++;
                    if (i_result.redundant !== want.redundant)
                        report_mismatch("redundant", int'(i_result.redundant),
                                        int'(want.redundant));
                    if (i_result.answer_valid !== want.answer_valid)
                        report_mismatch("answer_valid", int'(i_result.answer_valid),
                                        int'(want.answer_valid));
                    if (i_result.answer_a !== want.answer_a)
                        report_mismatch("answer_a", int'(i_result.answer_a),
                                        int'(want.answer_a));
                    if (i_result.answer_b !== want.answer_b)
                        report_mismatch("answer_b", int'(i_result.answer_b),
                                        int'(want.answer_b));
                end
            end
        end
        o_pending = answer_q.size();
    end

endmodule

// ===== test/union_find_redundant_edge_tb.sv =====
// Top of the redundant-edge detector testbench: clock, reset, edge word stimulus,
// watchdog and verdict. Depends on ufre_pkg, union_find_redundant_edge and ufre_checker.
module union_find_redundant_edge_tb;
    import ufre_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TOTAL_EDGES  = 1700;
    // A clear sweep over all NODES plus a long walk and the longest gap stays far below this.
    localparam int STALL_LIMIT  = 8000;
    localparam int DRAIN_CYCLES = 64;

    typedef enum int {
        PH_WINDOW,    // many edges over a few nodes: cycles and merges
        PH_BINOMIAL,  // balanced merges that grow rank and deep chains
        PH_WIDE,      // sparse edges over the whole id range
        PH_NOISE      // self loops, extreme ids, stray graph clears
    } t_phase_kind;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start   = 1'b0;
    t_edge   i_edge  = '0;
    logic    busy;
    logic    o_strobe;
    t_result o_result;

    int errors;
    int pending;
    int edges_seen;
    int redundant_seen;
    int clears_seen;
    int deepest_walk;

    int sent   = 0;
    logic steady = 1'b0;

    union_find_redundant_edge dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_edge   (i_edge),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    ufre_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_edge      (i_edge),
        .i_strobe    (o_strobe),
        .i_result    (o_result),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_edges     (edges_seen),
        .o_redundant (redundant_seen),
        .o_clears    (clears_seen),
        .o_deepest   (deepest_walk)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 0;
    end

    // Offer one edge word and return at the posedge that takes it. Idle first for a
    // random gap unless the current phase runs back to back. Busy is sampled on the
    // falling edge, where it is stable, so the handshake never races the block.
    task automatic send_edge(input logic [ID_W-1:0] a, input logic [ID_W-1:0] b,
                             input logic ng);
        int roll;
        int gap;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55)
            gap = 0;
        else if (roll < 85)
            gap = $urandom_range(1, 3);
        else if (roll < 97)
            gap = $urandom_range(4, 12);
        else
            gap = $urandom_range(20, 60);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_edge <= '{node_a: a, node_b: b, new_graph: ng};
        do @(negedge i_clk); while (busy);
        @(posedge i_clk);
        sent++;
    endtask

    // Watchdog: end the run when neither an edge word nor a result word moves for too long.
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(negedge i_clk);
            if (!i_rst_n || (start && !busy) || o_strobe)
                idle = 0;
            else
                idle++;
        end
        $display("timeout: no word moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        t_phase_kind kind;
        int          roll;
        int          n;
        int          span;
        int          base;
        int          size;
        int          s;
        int          a;
        int          b;
        int          tmp;
        logic        fresh;

        // Hold reset, then let the clear sweep run; send_edge waits on busy.
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, self loops, a triangle, each rank rule, a compressed
        // chain and a graph clear that must drop the latched answer.
        send_edge(10'd0,    10'd1023, 1'b1);  // join the two extreme ids
        send_edge(10'd1023, 10'd0,    1'b0);  // same pair reversed: redundant
        send_edge(10'd512,  10'd512,  1'b0);  // self loop
        send_edge(10'd0,    10'd0,    1'b0);
        send_edge(10'd1023, 10'd1023, 1'b0);
        send_edge(10'd1,    10'd2,    1'b0);
        send_edge(10'd2,    10'd3,    1'b0);
        send_edge(10'd3,    10'd1,    1'b0);  // closes the triangle
        send_edge(10'd1,    10'd3,    1'b1);  // fresh graph: not redundant, no answer
        send_edge(10'd4,    10'd5,    1'b0);  // equal rank: first root goes under second
        send_edge(10'd6,    10'd5,    1'b0);  // lower rank first
        send_edge(10'd5,    10'd7,    1'b0);  // higher rank first
        send_edge(10'd7,    10'd6,    1'b0);  // redundant through root 5
        send_edge(10'd10,   10'd11,   1'b0);
        send_edge(10'd8,    10'd9,    1'b0);
        send_edge(10'd11,   10'd9,    1'b0);  // rank 1 against rank 1
        send_edge(10'd10,   10'd5,    1'b0);  // walk 10 -> 11 -> 9 and compress
        send_edge(10'd7,    10'd10,   1'b0);  // 10 already compressed, 7 walks 7 -> 5 -> 9: redundant
        send_edge(10'd682,  10'd341,  1'b0);  // alternating bit patterns
        send_edge(10'd341,  10'd682,  1'b0);
        send_edge(10'd1023, 10'd1023, 1'b1);  // clear and close a loop at once

        // Random part: phases of related edges, most of them well-formed graphs.
        while (sent < TOTAL_EDGES) begin
            steady = ($urandom_range(0, 3) == 0);
            roll   = $urandom_range(0, 9);
            if (roll < 6)
                kind = PH_WINDOW;
            else if (roll < 8)
                kind = PH_BINOMIAL;
            else if (roll == 8)
                kind = PH_WIDE;
            else
                kind = PH_NOISE;

            case (kind)
                PH_WINDOW: begin
                    // Mostly tiny windows so cycles show up early; some wider ones.
                    span  = ($urandom_range(0, 9) < 7) ? $urandom_range(2, 8)
                                                       : $urandom_range(9, 64);
                    base  = $urandom_range(0, NODES - span);
                    n     = $urandom_range(10, 120);
                    fresh = ($urandom_range(0, 9) != 0);
                    for (int i = 0; i < n; i++) begin
                        a = base + $urandom_range(0, span - 1);
                        b = base + $urandom_range(0, span - 1);
                        send_edge(ID_W'(a), ID_W'(b), fresh && (i == 0));
                    end
                end
                PH_BINOMIAL: begin
                    // Merge pairs of equal sets level by level inside an aligned block,
                    // picking any member of each set so walks start deep in the tree.
                    size = 1 << $urandom_range(2, 8);
                    base = $urandom_range(0, NODES / size - 1) * size;
                    fresh = 1'b1;
                    for (s = 1; s < size; s = s * 2) begin
                        for (int k = 0; k < size; k += 2 * s) begin
                            a = base + k + $urandom_range(0, s - 1);
                            b = base + k + s + $urandom_range(0, s - 1);
                            if ($urandom_range(0, 1)) begin
                                tmp = a;
                                a   = b;
                                b   = tmp;
                            end
                            send_edge(ID_W'(a), ID_W'(b), fresh);
                            fresh = 1'b0;
                        end
                    end
                    // Probe the finished tree: every edge inside it is redundant.
                    n = $urandom_range(4, 10);
                    for (int i = 0; i < n; i++) begin
                        a = base + $urandom_range(0, size - 1);
                        b = base + $urandom_range(0, size - 1);
                        send_edge(ID_W'(a), ID_W'(b), 1'b0);
                    end
                end
                PH_WIDE: begin
                    n = $urandom_range(20, 60);
                    for (int i = 0; i < n; i++)
                        send_edge(ID_W'($urandom), ID_W'($urandom), 1'b0);
                end
                default: begin
                    n = $urandom_range(5, 20);
                    for (int i = 0; i < n; i++) begin
                        case ($urandom_range(0, 3))
                            0: begin
                                a = $urandom_range(0, NODES - 1);
                                send_edge(ID_W'(a), ID_W'(a), 1'b0);
                            end
                            1: send_edge($urandom_range(0, 1) ? 10'd1023 : 10'd0,
                                         $urandom_range(0, 1) ? 10'd1023 : 10'd0, 1'b0);
                            2: send_edge(ID_W'($urandom), ID_W'($urandom), 1'b0);
                            default: send_edge(ID_W'($urandom), ID_W'($urandom), 1'b1);
                        endcase
                    end
                end
            endcase
        end
        start <= 1'b0;

        // Drain: wait for every pending result word, then a little more for strays.
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d edge words over %0d graph clears, %0d of them redundant",
                 edges_seen, clears_seen, redundant_seen);
        $display("deepest root walk predicted: %0d steps", deepest_walk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
